// File: hw/rtl/sgps_pkg.sv
package sgps_pkg;

   localparam int OFFSET_W    = 8;
   localparam int COORD_W     = 12;
   localparam int PIXEL_W     = 13;
   localparam int COLOR_W     = 8;
   localparam int GLYPH_W     = 64;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int CELL_IDX_W  = 3;
   localparam int DIV_STEPS   = 4;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;

   localparam logic [COUNT_W-1:0] WEIGHT_CELL = 4'd4;
   localparam logic [COUNT_W-1:0] WEIGHT_LEFT = 4'd2;
   localparam logic [COUNT_W-1:0] WEIGHT_UP   = 4'd2;
   localparam logic [COUNT_W-1:0] WEIGHT_DIAG = 4'd1;
   localparam logic [COUNT_W-1:0] COUNT_FULL  = 4'd9;

   localparam int          RECIP9_W     = 13;
   localparam int          RECIP9_SHIFT = 16;
   localparam logic [12:0] RECIP9       = 13'd7282;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GLYPH_WIDTH  = 3'd0,
      CSR_GLYPH_HEIGHT = 3'd1,
      CSR_RED_LEVEL    = 3'd2,
      CSR_GREEN_LEVEL  = 3'd3,
      CSR_BLUE_LEVEL   = 3'd4
   } sgps_csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_x;
      logic [PIXEL_W-1:0] pixel_y;
   } sgps_pos_type;

   typedef struct packed {
      logic               mode;
      logic               blank;
      logic [GLYPH_W-1:0] bits;
      sgps_pos_type       pos;
   } sgps_side_type;

   typedef struct packed {
      logic               write_pixel;
      logic [COUNT_W-1:0] count;
   } sgps_cover_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } sgps_color_type;

endpackage

// File: hw/rtl/sgps_div_stage.sv
module sgps_div_stage #(
   parameter int DIV_W = 5,
   parameter int STEPS = 4
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [DIV_W-1:0]              divisor,
   input  logic [DIV_W-1:0]              prev_rem,
   input  logic [sgps_pkg::OFFSET_W-1:0] prev_num,
   output logic [DIV_W-1:0]              rem_ff,
   output logic [sgps_pkg::OFFSET_W-1:0] num_ff
);

   logic [DIV_W-1:0]              rem_in;
   logic [sgps_pkg::OFFSET_W-1:0] num_in;
   logic [DIV_W:0]                trial;

   // Restoring division: the dividend shifts out at the top while quotient
   // bits shift in at the bottom.
   always_comb begin
      rem_in = prev_rem;
      num_in = prev_num;
      trial  = '0;
      for (int i = 0; i < STEPS; i++) begin
         trial  = {rem_in, num_in[sgps_pkg::OFFSET_W-1]};
         num_in = {num_in[sgps_pkg::OFFSET_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial     = trial - {1'b0, divisor};
            num_in[0] = 1'b1;
         end
         rem_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

endmodule

// File: hw/rtl/sgps_coverage.sv
module sgps_coverage #(
   parameter int FONT_CELLS = 8
) (
   input  logic                          clock,
   input  logic                          enable,
   input  sgps_pkg::sgps_side_type       side,
   input  logic [sgps_pkg::OFFSET_W-1:0] quo_x,
   input  logic [sgps_pkg::OFFSET_W-1:0] quo_y,
   output sgps_pkg::sgps_cover_type      cover_ff
);

   localparam logic [sgps_pkg::OFFSET_W-1:0] CELLS = sgps_pkg::OFFSET_W'(FONT_CELLS);

   sgps_pkg::sgps_cover_type      cover_in;
   logic [sgps_pkg::OFFSET_W-1:0] left_x;
   logic [sgps_pkg::OFFSET_W-1:0] up_y;
   logic                          on_cell;
   logic                          on_left;
   logic                          on_up;
   logic                          on_diag;
   logic                          blank;
   logic [sgps_pkg::COUNT_W-1:0]  aa_count;

   function automatic logic cell_on(input logic [sgps_pkg::GLYPH_W-1:0]  bits,
                                    input logic [sgps_pkg::OFFSET_W-1:0] cx,
                                    input logic [sgps_pkg::OFFSET_W-1:0] cy);
      logic [2*sgps_pkg::CELL_IDX_W-1:0] idx;
      idx = {cy[sgps_pkg::CELL_IDX_W-1:0], cx[sgps_pkg::CELL_IDX_W-1:0]};
      return (cx < CELLS) && (cy < CELLS) && bits[idx];
   endfunction

   always_comb begin
      left_x   = quo_x - 1'b1;
      up_y     = quo_y - 1'b1;
      on_cell  = cell_on(side.bits, quo_x, quo_y);
      on_left  = (quo_x != '0) && cell_on(side.bits, left_x, quo_y);
      on_up    = (quo_y != '0) && cell_on(side.bits, quo_x, up_y);
      on_diag  = (quo_x != '0) && (quo_y != '0) && cell_on(side.bits, left_x, up_y);
      blank    = side.blank || (quo_y >= CELLS);
      aa_count = (on_cell ? sgps_pkg::WEIGHT_CELL : '0)
               + (on_left ? sgps_pkg::WEIGHT_LEFT : '0)
               + (on_up   ? sgps_pkg::WEIGHT_UP   : '0)
               + (on_diag ? sgps_pkg::WEIGHT_DIAG : '0);
      if (blank) begin
         cover_in.write_pixel = 1'b0;
         cover_in.count       = '0;
      end else if (side.mode) begin
         cover_in.write_pixel = 1'b1;
         cover_in.count       = aa_count;
      end else begin
         // Full weight reproduces the text color exactly after the divide by nine.
         cover_in.write_pixel = on_cell;
         cover_in.count       = on_cell ? sgps_pkg::COUNT_FULL : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cover_ff <= cover_in;
      end
   end

endmodule

// File: hw/rtl/sgps_shade.sv
module sgps_shade (
   input  logic                     clock,
   input  logic                     enable,
   input  sgps_pkg::sgps_cover_type cover_data,
   input  sgps_pkg::sgps_color_type level,
   output sgps_pkg::sgps_color_type color_ff
);

   localparam int PROD_W  = sgps_pkg::COLOR_W + sgps_pkg::COUNT_W;
   localparam int SCALE_W = PROD_W + sgps_pkg::RECIP9_W;

   logic [PROD_W-1:0]        prod_r_ff;
   logic [PROD_W-1:0]        prod_g_ff;
   logic [PROD_W-1:0]        prod_b_ff;
   logic [PROD_W-1:0]        prod_r_in;
   logic [PROD_W-1:0]        prod_g_in;
   logic [PROD_W-1:0]        prod_b_in;
   logic [SCALE_W-1:0]       scaled_r;
   logic [SCALE_W-1:0]       scaled_g;
   logic [SCALE_W-1:0]       scaled_b;
   sgps_pkg::sgps_color_type color_in;

   always_comb begin
      prod_r_in = PROD_W'(level.red)   * PROD_W'(cover_data.count);
      prod_g_in = PROD_W'(level.green) * PROD_W'(cover_data.count);
      prod_b_in = PROD_W'(level.blue)  * PROD_W'(cover_data.count);
   end

   // Division by nine as a multiply by the rounded-up reciprocal; exact for
   // products up to 255 times 9.
   always_comb begin
      scaled_r       = SCALE_W'(prod_r_ff) * SCALE_W'(sgps_pkg::RECIP9);
      scaled_g       = SCALE_W'(prod_g_ff) * SCALE_W'(sgps_pkg::RECIP9);
      scaled_b       = SCALE_W'(prod_b_ff) * SCALE_W'(sgps_pkg::RECIP9);
      color_in.red   = scaled_r[sgps_pkg::RECIP9_SHIFT +: sgps_pkg::COLOR_W];
      color_in.green = scaled_g[sgps_pkg::RECIP9_SHIFT +: sgps_pkg::COLOR_W];
      color_in.blue  = scaled_b[sgps_pkg::RECIP9_SHIFT +: sgps_pkg::COLOR_W];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         color_ff  <= color_in;
      end
   end

endmodule

// File: hw/rtl/scaled_glyph_pixel_shader.sv
// Shades one screen pixel of an 8x8 glyph drawn at an integer scale.
// Each request transaction carries the glyph bitmap, character code, glyph
// origin, the pixel offset inside the drawn glyph and the drawing mode.
// Each request yields exactly one response transaction with the screen
// position, a write flag and the pixel color, in request order.
// The configuration port sets glyph width and height and the text color;
// the user must write it only while no transactions are in flight; the
// block itself does not enforce this. One request is accepted per cycle
// while the response side is not stalled; the six-stage pipeline (input
// register, two divider stages of four quotient bits each, coverage lookup,
// color multiply, divide by nine) holds up to six transactions at once.
// When the receiver stalls, the whole pipeline holds and req_ready drops in
// the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and restores the default
// configuration: glyph size 8 by 8 and white text.
module scaled_glyph_pixel_shader #(
   parameter int FONT_CELLS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [7:0]                      req_char_code,
   input  logic [sgps_pkg::GLYPH_W-1:0]    req_glyph_bits,
   input  logic [sgps_pkg::COORD_W-1:0]    req_origin_x,
   input  logic [sgps_pkg::COORD_W-1:0]    req_origin_y,
   input  logic [sgps_pkg::OFFSET_W-1:0]   req_offset_col,
   input  logic [sgps_pkg::OFFSET_W-1:0]   req_offset_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_write_pixel,
   output logic [sgps_pkg::PIXEL_W-1:0]    rsp_pixel_x,
   output logic [sgps_pkg::PIXEL_W-1:0]    rsp_pixel_y,
   output logic [sgps_pkg::COLOR_W-1:0]    rsp_out_red,
   output logic [sgps_pkg::COLOR_W-1:0]    rsp_out_green,
   output logic [sgps_pkg::COLOR_W-1:0]    rsp_out_blue,
   input  logic                            csr_we,
   input  logic [sgps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SCALE_W       = $clog2(255 / FONT_CELLS + 1);
   localparam int RECIP_SHIFT   = 16;
   localparam int RECIP_W       = RECIP_SHIFT + 1;
   localparam int SCALE_RECIP   = ((1 << RECIP_SHIFT) + FONT_CELLS - 1) / FONT_CELLS;
   localparam int SCALE_PROD_W  = sgps_pkg::CSR_DATA_W + RECIP_W;
   localparam logic [SCALE_W-1:0] RESET_SCALE = SCALE_W'(8 / FONT_CELLS);

   logic [SCALE_W-1:0]             scale_x_ff;
   logic [SCALE_W-1:0]             scale_y_ff;
   sgps_pkg::sgps_color_type       level_ff;
   logic [SCALE_PROD_W-1:0]        scale_prod;
   logic [SCALE_W-1:0]             scale_raw;
   logic [SCALE_W-1:0]             scale_new;

   logic                           advance;
   logic                           s1_valid_ff;
   logic                           s2_valid_ff;
   logic                           s3_valid_ff;
   logic                           s4_valid_ff;
   logic                           s5_valid_ff;
   logic                           rsp_valid_ff;

   sgps_pkg::sgps_side_type        s1_side_in;
   sgps_pkg::sgps_side_type        s1_side_ff;
   logic [sgps_pkg::OFFSET_W-1:0]  s1_col_ff;
   logic [sgps_pkg::OFFSET_W-1:0]  s1_row_ff;
   sgps_pkg::sgps_side_type        s2_side_ff;
   sgps_pkg::sgps_side_type        s3_side_ff;
   logic [SCALE_W-1:0]             s2_rem_x;
   logic [SCALE_W-1:0]             s2_rem_y;
   logic [sgps_pkg::OFFSET_W-1:0]  s2_num_x;
   logic [sgps_pkg::OFFSET_W-1:0]  s2_num_y;
   logic [sgps_pkg::OFFSET_W-1:0]  s3_quo_x;
   logic [sgps_pkg::OFFSET_W-1:0]  s3_quo_y;
   sgps_pkg::sgps_cover_type       s4_cover;
   sgps_pkg::sgps_pos_type         s4_pos_ff;
   sgps_pkg::sgps_pos_type         s5_pos_ff;
   logic                           s5_write_ff;
   sgps_pkg::sgps_pos_type         rsp_pos_ff;
   logic                           rsp_write_ff;
   sgps_pkg::sgps_color_type       rsp_color;

   // Configuration registers; the scale is derived once at write time.
   always_comb begin
      scale_prod = SCALE_PROD_W'(csr_wdata) * SCALE_PROD_W'(SCALE_RECIP);
      scale_raw  = scale_prod[RECIP_SHIFT +: SCALE_W];
      scale_new  = (scale_raw == '0) ? SCALE_W'(1) : scale_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff     <= RESET_SCALE;
         scale_y_ff     <= RESET_SCALE;
         level_ff.red   <= '1;
         level_ff.green <= '1;
         level_ff.blue  <= '1;
      end else if (csr_we) begin
         case (csr_index)
            sgps_pkg::CSR_GLYPH_WIDTH:  scale_x_ff     <= scale_new;
            sgps_pkg::CSR_GLYPH_HEIGHT: scale_y_ff     <= scale_new;
            sgps_pkg::CSR_RED_LEVEL:    level_ff.red   <= csr_wdata;
            sgps_pkg::CSR_GREEN_LEVEL:  level_ff.green <= csr_wdata;
            sgps_pkg::CSR_BLUE_LEVEL:   level_ff.blue  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together unless the response is stalled.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_comb begin
      s1_side_in.mode        = req_mode;
      s1_side_in.blank       = (req_char_code == sgps_pkg::CHAR_SPACE)
                            || (req_char_code == sgps_pkg::CHAR_TAB);
      s1_side_in.bits        = req_glyph_bits;
      s1_side_in.pos.pixel_x = sgps_pkg::PIXEL_W'(req_origin_x)
                             + sgps_pkg::PIXEL_W'(req_offset_col);
      s1_side_in.pos.pixel_y = sgps_pkg::PIXEL_W'(req_origin_y)
                             + sgps_pkg::PIXEL_W'(req_offset_row);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff   <= s1_side_in;
         s1_col_ff    <= req_offset_col;
         s1_row_ff    <= req_offset_row;
         s2_side_ff   <= s1_side_ff;
         s3_side_ff   <= s2_side_ff;
         s4_pos_ff    <= s3_side_ff.pos;
         s5_pos_ff    <= s4_pos_ff;
         s5_write_ff  <= s4_cover.write_pixel;
         rsp_pos_ff   <= s5_pos_ff;
         rsp_write_ff <= s5_write_ff;
      end
   end

   sgps_div_stage #(.DIV_W(SCALE_W), .STEPS(sgps_pkg::DIV_STEPS)) u_div_x_hi (
      .clock    (clock),
      .enable   (advance),
      .divisor  (scale_x_ff),
      .prev_rem ('0),
      .prev_num (s1_col_ff),
      .rem_ff   (s2_rem_x),
      .num_ff   (s2_num_x)
   );

   sgps_div_stage #(.DIV_W(SCALE_W), .STEPS(sgps_pkg::DIV_STEPS)) u_div_y_hi (
      .clock    (clock),
      .enable   (advance),
      .divisor  (scale_y_ff),
      .prev_rem ('0),
      .prev_num (s1_row_ff),
      .rem_ff   (s2_rem_y),
      .num_ff   (s2_num_y)
   );

   sgps_div_stage #(.DIV_W(SCALE_W), .STEPS(sgps_pkg::DIV_STEPS)) u_div_x_lo (
      .clock    (clock),
      .enable   (advance),
      .divisor  (scale_x_ff),
      .prev_rem (s2_rem_x),
      .prev_num (s2_num_x),
      .rem_ff   (),
      .num_ff   (s3_quo_x)
   );

   sgps_div_stage #(.DIV_W(SCALE_W), .STEPS(sgps_pkg::DIV_STEPS)) u_div_y_lo (
      .clock    (clock),
      .enable   (advance),
      .divisor  (scale_y_ff),
      .prev_rem (s2_rem_y),
      .prev_num (s2_num_y),
      .rem_ff   (),
      .num_ff   (s3_quo_y)
   );

   sgps_coverage #(.FONT_CELLS(FONT_CELLS)) u_coverage (
      .clock    (clock),
      .enable   (advance),
      .side     (s3_side_ff),
      .quo_x    (s3_quo_x),
      .quo_y    (s3_quo_y),
      .cover_ff (s4_cover)
   );

   sgps_shade u_shade (
      .clock      (clock),
      .enable     (advance),
      .cover_data (s4_cover),
      .level      (level_ff),
      .color_ff   (rsp_color)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_pixel = rsp_write_ff;
   assign rsp_pixel_x     = rsp_pos_ff.pixel_x;
   assign rsp_pixel_y     = rsp_pos_ff.pixel_y;
   assign rsp_out_red     = rsp_color.red;
   assign rsp_out_green   = rsp_color.green;
   assign rsp_out_blue    = rsp_color.blue;

endmodule

// File: hw/rtl/sgps_checker.sv
module sgps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_write_pixel,
   input logic [sgps_pkg::PIXEL_W-1:0] rsp_pixel_x,
   input logic [sgps_pkg::PIXEL_W-1:0] rsp_pixel_y,
   input logic [sgps_pkg::COLOR_W-1:0] rsp_out_red,
   input logic [sgps_pkg::COLOR_W-1:0] rsp_out_green,
   input logic [sgps_pkg::COLOR_W-1:0] rsp_out_blue
);

   // A stalled response transaction keeps its position.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))
      else $error("stalled response changed");

   // Pixels that are not written carry a black color.
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_pixel |->
         rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0)
      else $error("unwritten pixel has nonzero color");

   // Requests are taken exactly when the response side is not stalled.
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == !(rsp_valid && !rsp_ready))
      else $error("request ready does not follow response flow");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind scaled_glyph_pixel_shader sgps_checker u_sgps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_write_pixel (rsp_write_pixel),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_out_red     (rsp_out_red),
   .rsp_out_green   (rsp_out_green),
   .rsp_out_blue    (rsp_out_blue)
);

// File: test/tb_scaled_glyph_pixel_shader.sv
module tb_scaled_glyph_pixel_shader;

   localparam int FONT_CELLS = 8;
   localparam logic MODE_PLAIN  = 1'b0;
   localparam logic MODE_SMOOTH = 1'b1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_AFTER = 150;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic                          mode;
      logic [7:0]                    char_code;
      logic [sgps_pkg::GLYPH_W-1:0]  glyph_bits;
      logic [sgps_pkg::COORD_W-1:0]  origin_x;
      logic [sgps_pkg::COORD_W-1:0]  origin_y;
      logic [sgps_pkg::OFFSET_W-1:0] offset_col;
      logic [sgps_pkg::OFFSET_W-1:0] offset_row;
   } glyph_pixel_type;

   typedef struct packed {
      logic                         write_pixel;
      logic [sgps_pkg::PIXEL_W-1:0] pixel_x;
      logic [sgps_pkg::PIXEL_W-1:0] pixel_y;
      logic [sgps_pkg::COLOR_W-1:0] red;
      logic [sgps_pkg::COLOR_W-1:0] green;
      logic [sgps_pkg::COLOR_W-1:0] blue;
   } shaded_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [7:0] req_char_code = '0;
   logic [sgps_pkg::GLYPH_W-1:0] req_glyph_bits = '0;
   logic [sgps_pkg::COORD_W-1:0] req_origin_x = '0;
   logic [sgps_pkg::COORD_W-1:0] req_origin_y = '0;
   logic [sgps_pkg::OFFSET_W-1:0] req_offset_col = '0;
   logic [sgps_pkg::OFFSET_W-1:0] req_offset_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_write_pixel;
   logic [sgps_pkg::PIXEL_W-1:0] rsp_pixel_x;
   logic [sgps_pkg::PIXEL_W-1:0] rsp_pixel_y;
   logic [sgps_pkg::COLOR_W-1:0] rsp_out_red;
   logic [sgps_pkg::COLOR_W-1:0] rsp_out_green;
   logic [sgps_pkg::COLOR_W-1:0] rsp_out_blue;
   logic csr_we = 1'b0;
   logic [sgps_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sgps_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [7:0] glyph_width_cfg = 8'd8;
   logic [7:0] glyph_height_cfg = 8'd8;
   logic [sgps_pkg::COLOR_W-1:0] red_cfg = 8'd255;
   logic [sgps_pkg::COLOR_W-1:0] green_cfg = 8'd255;
   logic [sgps_pkg::COLOR_W-1:0] blue_cfg = 8'd255;

   glyph_pixel_type pixels_to_send[$];
   shaded_pixel_type pixels_due[$];
   shaded_pixel_type seen_pixel;
   shaded_pixel_type due_pixel;
   glyph_pixel_type next_pixel;
   int queued_count = 0;
   int accepted_count = 0;
   int shaded_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int sink_stall = 0;
   int sink_hold = 0;
   bit sink_hold_done = 1'b0;
   bit steady = 1'b0;

   scaled_glyph_pixel_shader #(.FONT_CELLS(FONT_CELLS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_glyph_bits(req_glyph_bits),
      .req_origin_x(req_origin_x),
      .req_origin_y(req_origin_y),
      .req_offset_col(req_offset_col),
      .req_offset_row(req_offset_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_write_pixel(rsp_write_pixel),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int cell_scale(logic [7:0] size);
      int s;
      s = int'(size) / FONT_CELLS;
      return (s == 0) ? 1 : s;
   endfunction

   function automatic bit cell_lit(logic [sgps_pkg::GLYPH_W-1:0] bits, int cx, int cy);
      if (cx < 0 || cy < 0 || cx >= FONT_CELLS || cy >= FONT_CELLS) begin
         return 1'b0;
      end
      return bits[cy * 8 + cx];
   endfunction

   function automatic shaded_pixel_type shade_pixel(glyph_pixel_type p);
      shaded_pixel_type s;
      int fx;
      int fy;
      int coverage;
      s = '0;
      fx = int'(p.offset_col) / cell_scale(glyph_width_cfg);
      fy = int'(p.offset_row) / cell_scale(glyph_height_cfg);
      s.pixel_x = sgps_pkg::PIXEL_W'(p.origin_x) + sgps_pkg::PIXEL_W'(p.offset_col);
      s.pixel_y = sgps_pkg::PIXEL_W'(p.origin_y) + sgps_pkg::PIXEL_W'(p.offset_row);
      if (p.char_code != sgps_pkg::CHAR_SPACE && p.char_code != sgps_pkg::CHAR_TAB
          && fy < FONT_CELLS) begin
         if (p.mode == MODE_PLAIN) begin
            if (cell_lit(p.glyph_bits, fx, fy)) begin
               s.write_pixel = 1'b1;
               s.red = red_cfg;
               s.green = green_cfg;
               s.blue = blue_cfg;
            end
         end else begin
            coverage = 0;
            if (cell_lit(p.glyph_bits, fx, fy)) coverage += int'(sgps_pkg::WEIGHT_CELL);
            if (cell_lit(p.glyph_bits, fx - 1, fy)) coverage += int'(sgps_pkg::WEIGHT_LEFT);
            if (cell_lit(p.glyph_bits, fx, fy - 1)) coverage += int'(sgps_pkg::WEIGHT_UP);
            if (cell_lit(p.glyph_bits, fx - 1, fy - 1)) begin
               coverage += int'(sgps_pkg::WEIGHT_DIAG);
            end
            s.write_pixel = 1'b1;
            s.red = sgps_pkg::COLOR_W'(int'(red_cfg) * coverage
                                       / int'(sgps_pkg::COUNT_FULL));
            s.green = sgps_pkg::COLOR_W'(int'(green_cfg) * coverage
                                         / int'(sgps_pkg::COUNT_FULL));
            s.blue = sgps_pkg::COLOR_W'(int'(blue_cfg) * coverage
                                        / int'(sgps_pkg::COUNT_FULL));
         end
      end
      return s;
   endfunction

   function automatic glyph_pixel_type make_pixel(logic mode, logic [7:0] char_code,
                                                  logic [sgps_pkg::GLYPH_W-1:0] bits,
                                                  int ox, int oy, int col, int row);
      glyph_pixel_type p;
      p.mode = mode;
      p.char_code = char_code;
      p.glyph_bits = bits;
      p.origin_x = sgps_pkg::COORD_W'(ox);
      p.origin_y = sgps_pkg::COORD_W'(oy);
      p.offset_col = sgps_pkg::OFFSET_W'(col);
      p.offset_row = sgps_pkg::OFFSET_W'(row);
      return p;
   endfunction

   function automatic glyph_pixel_type random_pixel();
      glyph_pixel_type p;
      int span_x;
      int span_y;
      span_x = (FONT_CELLS + 1) * cell_scale(glyph_width_cfg) - 1;
      span_y = (FONT_CELLS + 1) * cell_scale(glyph_height_cfg) - 1;
      if (span_x > 254) span_x = 254;
      if (span_y > 254) span_y = 254;
      p.mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
         0: p.char_code = sgps_pkg::CHAR_SPACE;
         1: p.char_code = sgps_pkg::CHAR_TAB;
         default: p.char_code = 8'($urandom_range(0, 255));
      endcase
      p.glyph_bits = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: p.glyph_bits &= {$urandom, $urandom};
         1: p.glyph_bits |= {$urandom, $urandom};
         default: ;
      endcase
      p.origin_x = sgps_pkg::COORD_W'($urandom_range(0, 4095));
      p.origin_y = sgps_pkg::COORD_W'($urandom_range(0, 4095));
      p.offset_col = sgps_pkg::OFFSET_W'(($urandom_range(0, 7) == 0)
                                         ? $urandom_range(0, 254)
                                         : $urandom_range(0, span_x));
      p.offset_row = sgps_pkg::OFFSET_W'(($urandom_range(0, 7) == 0)
                                         ? $urandom_range(0, 254)
                                         : $urandom_range(0, span_y));
      return p;
   endfunction

   task automatic write_reg(sgps_pkg::sgps_csr_index_type index,
                            logic [sgps_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_shading(int width, int height, int red, int green, int blue);
      write_reg(sgps_pkg::CSR_GLYPH_WIDTH, sgps_pkg::CSR_DATA_W'(width));
      write_reg(sgps_pkg::CSR_GLYPH_HEIGHT, sgps_pkg::CSR_DATA_W'(height));
      write_reg(sgps_pkg::CSR_RED_LEVEL, sgps_pkg::CSR_DATA_W'(red));
      write_reg(sgps_pkg::CSR_GREEN_LEVEL, sgps_pkg::CSR_DATA_W'(green));
      write_reg(sgps_pkg::CSR_BLUE_LEVEL, sgps_pkg::CSR_DATA_W'(blue));
      glyph_width_cfg = 8'(width);
      glyph_height_cfg = 8'(height);
      red_cfg = sgps_pkg::COLOR_W'(red);
      green_cfg = sgps_pkg::COLOR_W'(green);
      blue_cfg = sgps_pkg::COLOR_W'(blue);
   endtask

   task automatic queue_pixel(glyph_pixel_type p);
      pixels_to_send.push_back(p);
      queued_count++;
   endtask

   task automatic queue_random(int count);
      repeat (count) queue_pixel(random_pixel());
   endtask

   task automatic wait_drained();
      while (shaded_count != queued_count) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            pixels_due.push_back(shade_pixel({req_mode, req_char_code, req_glyph_bits,
                                              req_origin_x, req_origin_y,
                                              req_offset_col, req_offset_row}));
            accepted_count <= accepted_count + 1;
         end
         if (req_valid && !req_ready) begin
         end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pixels_to_send.size() != 0) begin
            next_pixel = pixels_to_send.pop_front();
            req_mode <= next_pixel.mode;
            req_char_code <= next_pixel.char_code;
            req_glyph_bits <= next_pixel.glyph_bits;
            req_origin_x <= next_pixel.origin_x;
            req_origin_y <= next_pixel.origin_y;
            req_offset_col <= next_pixel.offset_col;
            req_offset_row <= next_pixel.offset_row;
            req_valid <= 1'b1;
            if (!steady && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_stall <= 0;
      end else if (sink_hold != 0) begin
         rsp_ready <= 1'b0;
         sink_hold <= sink_hold - 1;
      end else if (!sink_hold_done && accepted_count >= HOLD_AFTER) begin
         rsp_ready <= 1'b0;
         sink_hold_done <= 1'b1;
         sink_hold <= HOLD_CYCLES;
      end else if (sink_stall != 0) begin
         rsp_ready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         sink_stall <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_pixel = {rsp_write_pixel, rsp_pixel_x, rsp_pixel_y,
                       rsp_out_red, rsp_out_green, rsp_out_blue};
         if (pixels_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response transaction, expected none got %p",
                     $time, seen_pixel);
         end else begin
            due_pixel = pixels_due.pop_front();
            check_field("write_pixel", int'(due_pixel.write_pixel),
                        int'(seen_pixel.write_pixel));
            check_field("pixel_x", int'(due_pixel.pixel_x), int'(seen_pixel.pixel_x));
            check_field("pixel_y", int'(due_pixel.pixel_y), int'(seen_pixel.pixel_y));
            check_field("out_red", int'(due_pixel.red), int'(seen_pixel.red));
            check_field("out_green", int'(due_pixel.green), int'(seen_pixel.green));
            check_field("out_blue", int'(due_pixel.blue), int'(seen_pixel.blue));
         end
         shaded_count <= shaded_count + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Scale one with white text: cell, neighbor, blank and out-of-glyph cases.
      queue_pixel(make_pixel(MODE_PLAIN, 8'd65, '1, 0, 0, 0, 0));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd0, '0, 0, 0, 0, 0));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd255, 64'h1, 4095, 4095, 254, 254));
      queue_pixel(make_pixel(MODE_SMOOTH, sgps_pkg::CHAR_SPACE, '1, 100, 200, 3, 3));
      queue_pixel(make_pixel(MODE_PLAIN, sgps_pkg::CHAR_TAB, '1, 7, 9, 2, 2));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd66, '1, 0, 0, 0, 0));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd66, '1, 10, 10, 3, 3));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd66, '1, 10, 10, 3, 0));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd66, '1, 10, 10, 0, 5));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd67, '1, 20, 30, 8, 3));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd67, '1, 20, 30, 8, 8));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd67, '1, 20, 30, 200, 7));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd67, '1, 20, 30, 8, 2));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd68, 64'hAA55AA55AA55AA55, 1, 2, 1, 1));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd68, 64'hAA55AA55AA55AA55, 1, 2, 4, 6));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd69, 64'h8000000000000000, 4095, 0, 7, 7));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd69, 64'h8000000000000000, 0, 4095, 7, 7));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd69, 64'h8000000000000000, 0, 4095, 8, 8));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd31, '1, 2048, 1365, 4, 4));
      queue_pixel(make_pixel(MODE_PLAIN, 8'd33, 64'h5555555555555555, 2730, 0, 0, 7));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd8, 64'h00000000FFFFFFFF, 4095, 4095, 127, 128));
      queue_pixel(make_pixel(MODE_SMOOTH, 8'd10, 64'hFFFFFFFF00000000, 0, 0, 1, 4));
      wait_drained();

      set_shading(8, 8, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
      queue_random(100);
      wait_drained();

      set_shading(255, 255, 255, 0, 128);
      queue_random(100);
      wait_drained();

      set_shading(3, 0, 1, 254, $urandom_range(0, 255));
      queue_random(60);
      wait_drained();

      set_shading(16, 40, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
      queue_random(100);
      wait_drained();

      set_shading(200, 9, 0, $urandom_range(0, 255), 255);
      queue_random(100);
      wait_drained();

      steady = 1'b1;
      set_shading($urandom_range(8, 255), $urandom_range(8, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      queue_random(140);
      wait_drained();

      if (error_count == 0 && pixels_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: scaled_glyph_pixel_shader.f
hw/rtl/sgps_pkg.sv
hw/rtl/sgps_div_stage.sv
hw/rtl/sgps_coverage.sv
hw/rtl/sgps_shade.sv
hw/rtl/scaled_glyph_pixel_shader.sv
hw/rtl/sgps_checker.sv
test/tb_scaled_glyph_pixel_shader.sv
